### rtl/rgba_pixel_blend_unit_top_macros.svh
`ifndef RGBA_PIXEL_BLEND_UNIT_TOP_MACROS_SVH
`define RGBA_PIXEL_BLEND_UNIT_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define RPB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked while out of reset
`define RPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rpb_pkg.sv
`default_nettype none

package rpb_pkg;

   localparam int ChanW   = 8;
   localparam int NumChan = 4;
   localparam int ProdW   = 2 * ChanW;

   // channel order: red, green, blue, alpha
   localparam int ChAlpha = 3;

   typedef enum logic [2:0] {
      MODE_COPY  = 3'd0,
      MODE_MASK  = 3'd1,
      MODE_ALPHA = 3'd2,
      MODE_ADD   = 3'd3,
      MODE_MUL   = 3'd4
   } mode_type;

   typedef logic [NumChan-1:0][ChanW-1:0] chan4_type;
   typedef logic [NumChan-1:0][ProdW-1:0] prod4_type;

   // floor(x / 255), exact for x up to 255 * 255
   function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
      logic [ProdW:0] sum;
      sum = {1'b0, x} + {{(ChanW+1){1'b0}}, x[ProdW-1:ChanW]} + {{ProdW{1'b0}}, 1'b1};
      return sum[ProdW-1:ChanW];
   endfunction

endpackage

`default_nettype wire

### rtl/rgba_pixel_blend_unit_top.sv
`default_nettype none

// RGBA8888 blend unit: takes a source and destination pixel per transfer and
// returns the new destination pixel under the mode in csr_blend_mode (copy,
// mask, alpha blend, saturating add, multiply; other codes pass the
// destination through). Four register stages: operand select, 8x8 multiply
// per channel, divide by 255, final combine. One pixel per cycle sustained
// while rsp_ready stays high; a stall on rsp_ready holds the pipeline without
// loss while empty stages still fill. Write the mode only with no pixels in
// flight.
module rgba_pixel_blend_unit_top (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [2:0]             csr_blend_mode,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [rpb_pkg::ChanW-1:0] req_src_red,
   input  wire logic [rpb_pkg::ChanW-1:0] req_src_green,
   input  wire logic [rpb_pkg::ChanW-1:0] req_src_blue,
   input  wire logic [rpb_pkg::ChanW-1:0] req_src_alpha,
   input  wire logic [rpb_pkg::ChanW-1:0] req_dst_red,
   input  wire logic [rpb_pkg::ChanW-1:0] req_dst_green,
   input  wire logic [rpb_pkg::ChanW-1:0] req_dst_blue,
   input  wire logic [rpb_pkg::ChanW-1:0] req_dst_alpha,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [rpb_pkg::ChanW-1:0]   rsp_out_red,
   output logic [rpb_pkg::ChanW-1:0]   rsp_out_green,
   output logic [rpb_pkg::ChanW-1:0]   rsp_out_blue,
   output logic [rpb_pkg::ChanW-1:0]   rsp_out_alpha
);
   import rpb_pkg::*;

   `include "rgba_pixel_blend_unit_top_macros.svh"

   mode_type mode_ff, mode_in;

   // stage enables: a stage loads when it is empty or its content moves on
   logic en1, en2, en3, en4;

   // stage 1: operands
   logic        v1_ff, v1_in;
   mode_type    mode1_ff;
   chan4_type   src1_ff, dst1_ff, opa1_ff, opb1_ff;
   chan4_type   src_in, dst_in, opa_in, opb_in;
   logic [NumChan-1:0] neg1_ff, neg_in;

   // stage 2: products
   logic        v2_ff, v2_in;
   mode_type    mode2_ff;
   chan4_type   src2_ff, dst2_ff;
   logic [NumChan-1:0] neg2_ff;
   prod4_type   prod2_ff, prod_in;

   // stage 3: quotients
   logic        v3_ff, v3_in;
   mode_type    mode3_ff;
   chan4_type   src3_ff, dst3_ff, quo3_ff, quo_in;
   logic [NumChan-1:0] neg3_ff;

   // stage 4: result
   logic        v4_ff, v4_in;
   chan4_type   res4_ff, res_in;

   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_ready = en1;
   assign csr_ready = 1'b1;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   assign mode_in = (csr_valid && csr_ready) ? mode_type'(csr_blend_mode) : mode_ff;

   assign src_in = {req_src_alpha, req_src_blue, req_src_green, req_src_red};
   assign dst_in = {req_dst_alpha, req_dst_blue, req_dst_green, req_dst_red};

   // multiplier operands per channel
   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         opa_in[i] = '0;
         opb_in[i] = '0;
         neg_in[i] = 1'b0;
         unique case (mode_ff)
            MODE_MUL: begin
               opa_in[i] = dst_in[i];
               opb_in[i] = src_in[i];
            end
            MODE_ALPHA: begin
               if (i != ChAlpha) begin
                  neg_in[i] = src_in[i] < dst_in[i];
                  opa_in[i] = neg_in[i] ? (dst_in[i] - src_in[i])
                                        : (src_in[i] - dst_in[i]);
                  opb_in[i] = src_in[ChAlpha];
               end
            end
            MODE_ADD: begin
               if (i != ChAlpha) begin
                  opa_in[i] = src_in[i];
                  opb_in[i] = src_in[ChAlpha];
               end
            end
            default: begin
               opa_in[i] = '0;
               opb_in[i] = '0;
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         prod_in[i] = opa1_ff[i] * opb1_ff[i];
         quo_in[i]  = div255(prod2_ff[i]);
      end
   end

   // final combine
   always_comb begin
      logic [ChanW:0] sum;
      for (int i = 0; i < NumChan; i++) begin
         sum       = {1'b0, dst3_ff[i]} + {1'b0, quo3_ff[i]};
         res_in[i] = dst3_ff[i];
         unique case (mode3_ff)
            MODE_COPY: res_in[i] = src3_ff[i];
            MODE_MASK: begin
               if (src3_ff[ChAlpha] != '0) begin
                  res_in[i] = src3_ff[i];
               end
            end
            MODE_ALPHA: begin
               if (i != ChAlpha) begin
                  res_in[i] = neg3_ff[i] ? (dst3_ff[i] - quo3_ff[i])
                                         : (dst3_ff[i] + quo3_ff[i]);
               end
            end
            MODE_ADD: begin
               if (i != ChAlpha) begin
                  res_in[i] = sum[ChanW] ? {ChanW{1'b1}} : sum[ChanW-1:0];
               end
            end
            MODE_MUL: res_in[i] = quo3_ff[i];
            default:  res_in[i] = dst3_ff[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COPY;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         v4_ff   <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         mode1_ff <= mode_ff;
         src1_ff  <= src_in;
         dst1_ff  <= dst_in;
         opa1_ff  <= opa_in;
         opb1_ff  <= opb_in;
         neg1_ff  <= neg_in;
      end
      if (en2) begin
         mode2_ff <= mode1_ff;
         src2_ff  <= src1_ff;
         dst2_ff  <= dst1_ff;
         neg2_ff  <= neg1_ff;
         prod2_ff <= prod_in;
      end
      if (en3) begin
         mode3_ff <= mode2_ff;
         src3_ff  <= src2_ff;
         dst3_ff  <= dst2_ff;
         neg3_ff  <= neg2_ff;
         quo3_ff  <= quo_in;
      end
      if (en4) begin
         res4_ff <= res_in;
      end
   end

   assign rsp_valid     = v4_ff;
   assign rsp_out_red   = res4_ff[0];
   assign rsp_out_green = res4_ff[1];
   assign rsp_out_blue  = res4_ff[2];
   assign rsp_out_alpha = res4_ff[ChAlpha];

   `RPB_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_valid && req_ready, v1_ff,
      "accepted pixel did not enter the first stage")
   `RPB_ASSERT_NEXT(a_prod_held, clock, reset, v2_ff && !en3, v2_ff && $stable(prod2_ff),
      "stalled product stage lost or changed its data")
   `RPB_ASSERT_NOW(a_ready_when_empty, clock, reset, !v1_ff && !v2_ff && !v3_ff && !v4_ff,
      req_ready, "empty pipeline refused a pixel")

endmodule

`default_nettype wire

### sim/rgba_pixel_blend_unit_top_tb.sv
`timescale 1ns / 100ps

module rgba_pixel_blend_unit_top_tb;
   import rpb_pkg::*;

   localparam int unsigned ChanMax = 255;
   localparam int NumModeCodes = 8;
   localparam int NumRegimes = 3;
   localparam int BlockPixels = 73;
   localparam int TailCycles = 8;
   localparam int ResetCycles = 6;
   localparam int CycleLimit = 200000;
   localparam int MaxReports = 10;

   // codes past multiply: destination passes through
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
      logic [ChanW-1:0] alpha;
   } rgba_pixel_type;

   typedef struct packed {
      logic [2:0]     mode;
      rgba_pixel_type src;
      rgba_pixel_type dst;
      logic           typed;
      rgba_pixel_type want;
   } blend_case_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;

   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_blend_mode = '0;

   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [ChanW-1:0] req_src_red = '0;
   logic [ChanW-1:0] req_src_green = '0;
   logic [ChanW-1:0] req_src_blue = '0;
   logic [ChanW-1:0] req_src_alpha = '0;
   logic [ChanW-1:0] req_dst_red = '0;
   logic [ChanW-1:0] req_dst_green = '0;
   logic [ChanW-1:0] req_dst_blue = '0;
   logic [ChanW-1:0] req_dst_alpha = '0;

   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [ChanW-1:0] rsp_out_red;
   logic [ChanW-1:0] rsp_out_green;
   logic [ChanW-1:0] rsp_out_blue;
   logic [ChanW-1:0] rsp_out_alpha;

   rgba_pixel_type   expected_pixels [$];
   blend_case_type   blend_cases [32];
   int               num_cases = 0;
   logic [2:0]       blend_mode_shadow = MODE_COPY;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               mismatches = 0;
   int               results_checked = 0;
   int               pixels_sent = 0;
   int               mode_writes = 0;
   int               cycle_count = 0;
   int               mode_hits [NumModeCodes];

   always #1 clock = ~clock;

   rgba_pixel_blend_unit_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_blend_mode (csr_blend_mode),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_src_red    (req_src_red),
      .req_src_green  (req_src_green),
      .req_src_blue   (req_src_blue),
      .req_src_alpha  (req_src_alpha),
      .req_dst_red    (req_dst_red),
      .req_dst_green  (req_dst_green),
      .req_dst_blue   (req_dst_blue),
      .req_dst_alpha  (req_dst_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha)
   );

   // moves dst toward src by (src - dst) * a / 255, truncated toward zero
   function automatic int unsigned blend_toward(input int unsigned s, d, a);
      if (s >= d) begin
         return d + (s - d) * a / ChanMax;
      end
      return d - (d - s) * a / ChanMax;
   endfunction

   function automatic int unsigned add_clamped(input int unsigned s, d, a);
      int unsigned sum;
      sum = d + s * a / ChanMax;
      return (sum > ChanMax) ? ChanMax : sum;
   endfunction

   function automatic int unsigned scale_channel(input int unsigned s, d);
      return d * s / ChanMax;
   endfunction

   function automatic rgba_pixel_type predict_blend(input logic [2:0] mode,
                                                    input rgba_pixel_type s, d);
      rgba_pixel_type r;
      r = d;
      case (mode)
         MODE_COPY: r = s;
         MODE_MASK: begin
            if (s.alpha != '0) r = s;
         end
         MODE_ALPHA: begin
            r.red   = ChanW'(blend_toward(s.red, d.red, s.alpha));
            r.green = ChanW'(blend_toward(s.green, d.green, s.alpha));
            r.blue  = ChanW'(blend_toward(s.blue, d.blue, s.alpha));
         end
         MODE_ADD: begin
            r.red   = ChanW'(add_clamped(s.red, d.red, s.alpha));
            r.green = ChanW'(add_clamped(s.green, d.green, s.alpha));
            r.blue  = ChanW'(add_clamped(s.blue, d.blue, s.alpha));
         end
         MODE_MUL: begin
            r.red   = ChanW'(scale_channel(s.red, d.red));
            r.green = ChanW'(scale_channel(s.green, d.green));
            r.blue  = ChanW'(scale_channel(s.blue, d.blue));
            r.alpha = ChanW'(scale_channel(s.alpha, d.alpha));
         end
         default: ;
      endcase
      return r;
   endfunction

   // extremes show up often so that clamping and alpha edges get hit
   function automatic logic [ChanW-1:0] random_channel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return ChanW'($urandom_range(ChanMax));
      endcase
   endfunction

   function automatic rgba_pixel_type random_pixel();
      rgba_pixel_type p;
      p.red   = random_channel();
      p.green = random_channel();
      p.blue  = random_channel();
      p.alpha = random_channel();
      return p;
   endfunction

   task automatic add_case(input logic [2:0] m, input rgba_pixel_type s, d,
                           input logic typed, input rgba_pixel_type want);
      blend_cases[num_cases] = {m, s, d, typed, want};
      num_cases++;
   endtask

   // always advances at least one edge, so valid is never re-raised in the same step
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   task automatic write_blend_mode(input logic [2:0] code);
      drain_pipeline();
      csr_valid      <= 1'b1;
      csr_blend_mode <= code;
      do @(posedge clock); while (!csr_ready);
      csr_valid         <= 1'b0;
      blend_mode_shadow = code;
      mode_writes++;
   endtask

   task automatic send_pixel(input rgba_pixel_type src, dst, input logic typed,
                             input rgba_pixel_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_src_red   <= src.red;
      req_src_green <= src.green;
      req_src_blue  <= src.blue;
      req_src_alpha <= src.alpha;
      req_dst_red   <= dst.red;
      req_dst_green <= dst.green;
      req_dst_blue  <= dst.blue;
      req_dst_alpha <= dst.alpha;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(typed ? want : predict_blend(blend_mode_shadow, src, dst));
      mode_hits[blend_mode_shadow]++;
      pixels_sent++;
   endtask

   task automatic check_result();
      rgba_pixel_type got;
      rgba_pixel_type want;
      got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha};
      results_checked++;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= MaxReports)
            $display("result %0d: pixel %h arrived with nothing pending",
                     results_checked, got);
      end else begin
         want = expected_pixels.pop_front();
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.alpha !== want.alpha) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("result %0d: expected r%h g%h b%h a%h, got r%h g%h b%h a%h",
                        results_checked, want.red, want.green, want.blue, want.alpha,
                        got.red, got.green, got.blue, got.alpha);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, expected_pixels.size());
         $display("rgba_pixel_blend_unit_top regression: fail");
         $finish;
      end
   end

   initial begin
      int             regime;
      int             blk;
      int             n;
      int             pause_at;
      logic [2:0]     code;
      blend_case_type bc;

      add_case(MODE_COPY, 32'hffffffff, 32'h00000000, 1'b1, 32'hffffffff);
      add_case(MODE_COPY, 32'h00000000, 32'hffffffff, 1'b1, 32'h00000000);
      add_case(MODE_COPY, 32'h12345678, 32'h9abcdef0, 1'b1, 32'h12345678);
      add_case(MODE_MASK, 32'hffffff00, 32'h11223344, 1'b1, 32'h11223344);
      add_case(MODE_MASK, 32'haabbcc01, 32'h00000000, 1'b1, 32'haabbcc01);
      add_case(MODE_MASK, 32'h010203ff, 32'hffffffff, 1'b1, 32'h010203ff);
      add_case(MODE_ALPHA, 32'hffffff00, 32'h10203040, 1'b1, 32'h10203040);
      add_case(MODE_ALPHA, 32'hff0080ff, 32'h00ff4077, 1'b1, 32'hff008077);
      add_case(MODE_ALPHA, 32'hffffff80, 32'h00000011, 1'b0, 32'h0);
      add_case(MODE_ALPHA, 32'h00000080, 32'hffffff22, 1'b0, 32'h0);
      add_case(MODE_ALPHA, 32'h7f80c17f, 32'h817f3e55, 1'b0, 32'h0);
      add_case(MODE_ADD, 32'h000000ff, 32'h12345678, 1'b1, 32'h12345678);
      add_case(MODE_ADD, 32'hffffffff, 32'hffffff00, 1'b1, 32'hffffff00);
      add_case(MODE_ADD, 32'hffffffff, 32'h010101aa, 1'b1, 32'hffffffaa);
      add_case(MODE_ADD, 32'h80808080, 32'h40c0fe33, 1'b0, 32'h0);
      add_case(MODE_ADD, 32'hffffff00, 32'hfefefe01, 1'b1, 32'hfefefe01);
      add_case(MODE_MUL, 32'hffffffff, 32'h3c5a96c3, 1'b1, 32'h3c5a96c3);
      add_case(MODE_MUL, 32'h00000000, 32'hffffffff, 1'b1, 32'h00000000);
      add_case(MODE_MUL, 32'h80808080, 32'h80ff017f, 1'b0, 32'h0);
      add_case(MODE_MUL, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff);
      add_case(MODE_SPARE_LO, 32'hffffffff, 32'h12345678, 1'b1, 32'h12345678);
      add_case(MODE_SPARE_HI, 32'h00000000, 32'hffffffff, 1'b1, 32'hffffffff);
      add_case(MODE_COPY, 32'ha55ac33c, 32'h5aa53cc3, 1'b1, 32'ha55ac33c);

      send_idle_pct = 21;
      rsp_stall_pct = 73;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first rows run on the reset value of the mode register
      for (n = 0; n < num_cases; n++) begin
         bc = blend_cases[n];
         if (bc.mode != blend_mode_shadow) write_blend_mode(bc.mode);
         send_pixel(bc.src, bc.dst, bc.typed, bc.want);
      end

      for (regime = 0; regime < NumRegimes; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 21;
               rsp_stall_pct = 73;
            end
            1: begin
               send_idle_pct = 73;
               rsp_stall_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (blk = 0; blk < NumModeCodes; blk++) begin
            code = 3'((blk + 3 * regime) % NumModeCodes);
            write_blend_mode(code);
            pause_at = $urandom_range(BlockPixels - 1);
            for (n = 0; n < BlockPixels; n++) begin
               // hold the sender until the pipeline is empty once per regime
               if (blk == 2 && n == pause_at) drain_pipeline();
               send_pixel(random_pixel(), random_pixel(), 1'b0, '0);
            end
         end
      end

      drain_pipeline();
      repeat (TailCycles) @(posedge clock);

      $display("covered %0d pixels over %0d mode writes, %0d results compared, %0d bad",
               pixels_sent, mode_writes, results_checked, mismatches);
      $display("pixels per mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
               mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("rgba_pixel_blend_unit_top regression: pass");
      end else begin
         $display("rgba_pixel_blend_unit_top regression: fail");
      end
      $finish;
   end

endmodule
